// ===== hw/rtl/bmpa_pkg.sv =====
// shared constants and controller/datapath types for the binned minute power averager
package bmpa_pkg;

   // default sizing
   localparam int SLOT_COUNT_DEFAULT  = 60;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // field widths
   localparam int RAW_W  = 16;
   localparam int SLOT_W = 6;
   localparam int COEF_W = 24;
   localparam int OUT_W  = 32;
   localparam int SUM_W  = 48;

   // product of raw reading and coefficient, and the fraction bits dropped from it
   localparam int PROD_W    = RAW_W + COEF_W;
   localparam int FRAC_DROP = 8;

   // wide enough to hold any slot count in range for the range compare
   localparam int SLOT_CMP_W = 9;

   // coefficient after reset is 1.0 in 8.16 fixed point
   localparam logic [COEF_W-1:0] COEF_RESET = 24'd65536;

   typedef struct packed {
      logic capture;     // take the input item, form the product
      logic rd_slot;     // read the addressed bin
      logic wr_slot;     // write back the updated bin
      logic scan_clear;  // restart scan index, total and used count
      logic scan_rd;     // read the bin at the scan index
      logic advance;     // step the scan index
      logic div_bin;     // load divider with bin sum / bin count
      logic div_final;   // load divider with total / used
      logic div_step;    // one restoring division step
      logic accum;       // add bin mean into total
      logic load_out;    // fill the result register
   } bmpa_cmd_type;

   typedef struct packed {
      logic slot_in_range;
      logic idx_valid;
      logic idx_last;
      logic div_done;
      logic used_zero;
   } bmpa_status_type;

endpackage

// ===== hw/rtl/bmpa_if.sv =====
// valid/ready channel interfaces for input items, results and the coefficient register
interface bmpa_req_if
   import bmpa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [RAW_W-1:0]  raw_power;
   logic [SLOT_W-1:0] second_slot;

   modport source (output valid, output raw_power, output second_slot, input ready);
   modport sink   (input valid, input raw_power, input second_slot, output ready);
endinterface

interface bmpa_rsp_if
   import bmpa_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] power_scaled;
   logic [OUT_W-1:0] avg_power;
   logic             avg_valid;

   modport source (output valid, output power_scaled, output avg_power, output avg_valid,
                   input ready);
   modport sink   (input valid, input power_scaled, input avg_power, input avg_valid,
                   output ready);
endinterface

interface bmpa_csr_if
   import bmpa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COEF_W-1:0] power_coef;

   modport source (output valid, output power_coef, input ready);
   modport sink   (input valid, input power_coef, output ready);
endinterface

// ===== hw/rtl/bmpa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module bmpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bmpa_datapath.sv =====
// bin store, scaling multiplier, shared divider and result register
module bmpa_datapath
   import bmpa_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr,
   input  logic [COEF_W-1:0] csr_data,
   input  logic [RAW_W-1:0]  raw_power,
   input  logic [SLOT_W-1:0] second_slot,
   input  bmpa_cmd_type      cmd,
   output bmpa_status_type   status,
   output logic [OUT_W-1:0]  power_scaled,
   output logic [OUT_W-1:0]  avg_power,
   output logic              avg_valid
);

   localparam int AW      = $clog2(SLOT_COUNT);
   localparam int USED_W  = $clog2(SLOT_COUNT + 1);
   localparam int NUM_W   = SUM_W + $clog2(SLOT_COUNT);
   localparam int DEN_W   = (COUNT_WIDTH > USED_W) ? COUNT_WIDTH : USED_W;
   localparam int STEP_W  = $clog2(NUM_W + 1);
   localparam int ENTRY_W = SUM_W + COUNT_WIDTH;
   localparam logic [SUM_W-1:0]       SUM_MAX   = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [AW-1:0]          LAST_IDX  = AW'(SLOT_COUNT - 1);

   logic [COEF_W-1:0]     coef_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     active_ff;
   logic [SLOT_COUNT-1:0] bin_valid_ff;
   logic [AW-1:0]         idx_ff;
   logic [NUM_W-1:0]      total_ff;
   logic [USED_W-1:0]     used_ff;
   logic [NUM_W-1:0]      quo_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [OUT_W-1:0]      power_scaled_ff;
   logic [OUT_W-1:0]      avg_power_ff;
   logic                  avg_valid_ff;

   logic [AW-1:0]          slot_addr;
   logic [AW-1:0]          rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   wr_en;
   logic [SUM_W-1:0]       old_sum;
   logic [COUNT_WIDTH-1:0] old_count;
   logic                   fresh;
   logic [SUM_W-1:0]       base_sum;
   logic [COUNT_WIDTH-1:0] base_count;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       new_sum;
   logic [OUT_W-1:0]       scaled;
   logic [DEN_W:0]         trial;
   logic [DEN_W:0]         diff;
   logic                   trial_ge;

   assign scaled    = prod_ff[FRAC_DROP +: OUT_W];
   assign slot_addr = AW'(slot_ff);
   assign rd_addr   = cmd.rd_slot ? slot_addr : idx_ff;
   assign old_sum   = rd_data[ENTRY_W-1 -: SUM_W];
   assign old_count = rd_data[COUNT_WIDTH-1:0];

   // a bin is taken as empty when never filled or when the slot has moved on to it
   assign fresh      = !bin_valid_ff[slot_addr] || (active_ff != slot_ff);
   assign base_sum   = fresh ? '0 : old_sum;
   assign base_count = fresh ? '0 : old_count;
   assign sum_wide   = {1'b0, base_sum} + (SUM_W + 1)'(scaled);
   assign new_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign wr_data    = {new_sum, base_count + COUNT_WIDTH'(1)};
   assign wr_en      = cmd.wr_slot && (base_count != COUNT_MAX);

   // restoring divider step
   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign trial_ge = trial >= {1'b0, den_ff};

   bmpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_slot | cmd.scan_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         active_ff    <= '0;
         bin_valid_ff <= '0;
         step_ff      <= '0;
      end else begin
         if (csr_wr) begin
            coef_ff <= csr_data;
         end
         if (cmd.wr_slot) begin
            bin_valid_ff[slot_addr] <= 1'b1;
            active_ff               <= slot_ff;
         end
         if (cmd.div_bin || cmd.div_final) begin
            step_ff <= STEP_W'(NUM_W);
         end else if (cmd.div_step) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff <= {{COEF_W{1'b0}}, raw_power} * {{RAW_W{1'b0}}, coef_ff};
         slot_ff <= second_slot;
      end
      if (cmd.scan_clear) begin
         idx_ff   <= '0;
         total_ff <= '0;
         used_ff  <= '0;
      end else begin
         if (cmd.advance) begin
            idx_ff <= idx_ff + AW'(1);
         end
         if (cmd.accum) begin
            total_ff <= total_ff + quo_ff;
            used_ff  <= used_ff + USED_W'(1);
         end
      end
      if (cmd.div_bin) begin
         quo_ff <= NUM_W'(old_sum);
         den_ff <= DEN_W'(old_count);
         rem_ff <= '0;
      end else if (cmd.div_final) begin
         quo_ff <= total_ff;
         den_ff <= DEN_W'(used_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[NUM_W-2:0], trial_ge};
         rem_ff <= trial_ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
      if (cmd.load_out) begin
         power_scaled_ff <= scaled;
         avg_power_ff    <= (used_ff == '0) ? '0 : quo_ff[OUT_W-1:0];
         avg_valid_ff    <= (used_ff != '0);
      end
   end

   always_comb begin
      status.slot_in_range = SLOT_CMP_W'(slot_ff) < SLOT_CMP_W'(SLOT_COUNT);
      status.idx_valid     = bin_valid_ff[idx_ff];
      status.idx_last      = (idx_ff == LAST_IDX);
      status.div_done      = (step_ff == '0);
      status.used_zero     = (used_ff == '0);
   end

   assign power_scaled = power_scaled_ff;
   assign avg_power    = avg_power_ff;
   assign avg_valid    = avg_valid_ff;

endmodule

// ===== hw/rtl/bmpa_controller.sv =====
// sequencer for bin update, bin scan, divisions and result hand-off
module bmpa_controller
   import bmpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  bmpa_status_type status,
   output bmpa_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOT_RD,
      ST_SLOT_WR,
      ST_SCAN_INIT,
      ST_SCAN_RD,
      ST_SCAN_LOAD,
      ST_DIV_BIN,
      ST_ACCUM,
      ST_FINAL,
      ST_DIV_FINAL,
      ST_PUBLISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: begin
            if (status.slot_in_range) begin
               cmd.rd_slot = 1'b1;
               state_in    = ST_SLOT_WR;
            end else begin
               state_in = ST_SCAN_INIT;
            end
         end
         ST_SLOT_WR: begin
            cmd.wr_slot = 1'b1;
            state_in    = ST_SCAN_INIT;
         end
         ST_SCAN_INIT: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (status.idx_valid) begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_LOAD;
            end else if (status.idx_last) begin
               state_in = ST_FINAL;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_SCAN_LOAD: begin
            cmd.div_bin = 1'b1;
            state_in    = ST_DIV_BIN;
         end
         ST_DIV_BIN: begin
            if (status.div_done) begin
               state_in = ST_ACCUM;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.idx_last) begin
               state_in = ST_FINAL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_FINAL: begin
            if (status.used_zero) begin
               state_in = ST_PUBLISH;
            end else begin
               cmd.div_final = 1'b1;
               state_in      = ST_DIV_FINAL;
            end
         end
         ST_DIV_FINAL: begin
            if (status.div_done) begin
               state_in = ST_PUBLISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/binned_minute_power_averager.sv =====
// top level of the binned minute power averager
//
// each transfer on req carries a raw power reading and a second-of-minute slot; the reading
// is scaled by power_coef (8.16 fixed point) into watts with 8 fraction bits and accumulated
// into one of SLOT_COUNT one-second bins, each holding a saturating 48-bit sum and a
// saturating COUNT_WIDTH-bit count. moving to a different slot empties that bin first; a slot
// of SLOT_COUNT or above leaves the store untouched. every item gives exactly one transfer on
// rsp with the scaled reading and the mean of the per-bin means over non-empty bins
// (truncating), avg_valid low and avg_power zero while all bins are empty. one item is in
// work at a time. the single shared restoring divider retires one quotient bit per cycle,
// and the scan walks the bins through the one read port of the bin ram. a finished result
// waits in its output register while the next item is taken and worked on; that next item
// then stalls in its last cycle until the waiting result has been taken. bins are emptied
// at reset by per-bin valid flags, so there is no clearing pass. the coefficient register
// is always ready and should only be written while the block is idle
module binned_minute_power_averager
   import bmpa_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bmpa_req_if.sink   req_ch,
   bmpa_rsp_if.source rsp_ch,
   bmpa_csr_if.sink   csr_ch
);

   bmpa_cmd_type    cmd;
   bmpa_status_type status;

   // coefficient writes are taken in any cycle
   assign csr_ch.ready = 1'b1;

   // sequencer: one item at a time through update, scan and divisions
   bmpa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // bin store, multiplier, divider and result register
   bmpa_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr       (csr_ch.valid & csr_ch.ready),
      .csr_data     (csr_ch.power_coef),
      .raw_power    (req_ch.raw_power),
      .second_slot  (req_ch.second_slot),
      .cmd          (cmd),
      .status       (status),
      .power_scaled (rsp_ch.power_scaled),
      .avg_power    (rsp_ch.avg_power),
      .avg_valid    (rsp_ch.avg_valid)
   );

endmodule

// ===== hw/rtl/bmpa_checker.sv =====
// port-level checks for the binned minute power averager, bound to the top level
module bmpa_checker
   import bmpa_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] power_scaled,
   input logic [OUT_W-1:0] avg_power,
   input logic             avg_valid
);

   // no result is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(power_scaled) && $stable(avg_power)
                                  && $stable(avg_valid))
      else $error("stalled result changed");

   // empty store reports a zero mean
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !avg_valid |-> avg_power == '0)
      else $error("mean not zero while no bin holds readings");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous item still in work");

endmodule

bind binned_minute_power_averager bmpa_checker u_bmpa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .power_scaled (rsp_ch.power_scaled),
   .avg_power    (rsp_ch.avg_power),
   .avg_valid    (rsp_ch.avg_valid)
);
